// ----- rtl/rti_pkg.sv -----
// Shared widths, register codes and stage record types for the ray-triangle intersector.
package rti_pkg;

	localparam int COORD_W = 16;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int EDGE_W = COORD_W + 1;
	localparam int PROD1_W = 2 * EDGE_W;
	localparam int CROSS_W = PROD1_W + 1;
	localparam int PROD2_W = EDGE_W + CROSS_W;
	localparam int SUM_W = PROD2_W + 2;
	localparam int DIV_W = SUM_W;
	localparam int FRAC_W = 16;
	localparam int DIV_STEPS = 31;
	localparam int LANES = 3;
	localparam int T_W = 32;
	localparam int BARY_W = 17;
	localparam int IDX_W = 3;
	localparam int FRONT_STAGES = 5;

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_ORIGIN_Z    = 3'd2,
		REG_DIRECTION_X = 3'd3,
		REG_DIRECTION_Y = 3'd4,
		REG_DIRECTION_Z = 3'd5
	} cfg_reg_t;

	localparam logic signed [COORD_W-1:0] DIR_Z_RESET = 16'sd256;

	typedef struct packed {
		logic                    valid;
		logic signed [SUM_W-1:0] det;
		logic signed [SUM_W-1:0] u;
		logic signed [SUM_W-1:0] v;
		logic signed [SUM_W-1:0] tn;
	} rti_front_t;

	typedef struct packed {
		logic hit;
		logic neg;
		logic sat;
	} rti_tag_t;

endpackage

// ----- rtl/rti_front.sv -----
// Five-stage datapath from vertices and ray to determinant, U, V and the t numerator.
module rti_front import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [COORD_W-1:0] org [3],
	input  logic signed [COORD_W-1:0] dir [3],
	input  logic signed [COORD_W-1:0] vtx [9],
	output rti_front_t                res
);

	localparam int EFF_W = (COORD_WIDTH > COORD_W) ? COORD_W : COORD_WIDTH;
	localparam int SH = COORD_W - EFF_W;

	logic signed [COORD_W-1:0] o_x [3];
	logic signed [COORD_W-1:0] d_x [3];
	logic signed [COORD_W-1:0] p_x [9];

	logic                      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [EDGE_W-1:0]  e1_s1 [3], e2_s1 [3], tv_s1 [3];
	logic signed [COORD_W-1:0] d_s1 [3];
	logic signed [EDGE_W-1:0]  e1_s2 [3], e2_s2 [3], tv_s2 [3];
	logic signed [COORD_W-1:0] d_s2 [3];
	logic signed [PROD1_W-1:0] pp_s2 [6], qp_s2 [6];
	logic signed [EDGE_W-1:0]  e1_s3 [3], e2_s3 [3], tv_s3 [3];
	logic signed [COORD_W-1:0] d_s3 [3];
	logic signed [CROSS_W-1:0] p_s3 [3], q_s3 [3];
	logic signed [PROD2_W-1:0] dp_s4 [3], up_s4 [3], vp_s4 [3], tp_s4 [3];
	logic signed [SUM_W-1:0]   det_s5, u_s5, v_s5, tn_s5;

	function automatic logic signed [COORD_W-1:0] sx(input logic signed [COORD_W-1:0] x);
		logic signed [COORD_W-1:0] t;
		t = x <<< SH;
		return t >>> SH;
	endfunction

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			o_x[i] = sx(org[i]);
			d_x[i] = sx(dir[i]);
		end
		for (int i = 0; i < 9; i++) begin
			p_x[i] = sx(vtx[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e1_s1[i] <= EDGE_W'(p_x[3 + i]) - EDGE_W'(p_x[i]);
			e2_s1[i] <= EDGE_W'(p_x[6 + i]) - EDGE_W'(p_x[i]);
			tv_s1[i] <= EDGE_W'(o_x[i]) - EDGE_W'(p_x[i]);
			d_s1[i]  <= d_x[i];
		end
	end

	always_ff @(posedge clk) begin
		e1_s2 <= e1_s1;
		e2_s2 <= e2_s1;
		tv_s2 <= tv_s1;
		d_s2  <= d_s1;
		pp_s2[0] <= PROD1_W'(d_s1[1]) * PROD1_W'(e2_s1[2]);
		pp_s2[1] <= PROD1_W'(d_s1[2]) * PROD1_W'(e2_s1[1]);
		pp_s2[2] <= PROD1_W'(d_s1[2]) * PROD1_W'(e2_s1[0]);
		pp_s2[3] <= PROD1_W'(d_s1[0]) * PROD1_W'(e2_s1[2]);
		pp_s2[4] <= PROD1_W'(d_s1[0]) * PROD1_W'(e2_s1[1]);
		pp_s2[5] <= PROD1_W'(d_s1[1]) * PROD1_W'(e2_s1[0]);
		qp_s2[0] <= PROD1_W'(tv_s1[1]) * PROD1_W'(e1_s1[2]);
		qp_s2[1] <= PROD1_W'(tv_s1[2]) * PROD1_W'(e1_s1[1]);
		qp_s2[2] <= PROD1_W'(tv_s1[2]) * PROD1_W'(e1_s1[0]);
		qp_s2[3] <= PROD1_W'(tv_s1[0]) * PROD1_W'(e1_s1[2]);
		qp_s2[4] <= PROD1_W'(tv_s1[0]) * PROD1_W'(e1_s1[1]);
		qp_s2[5] <= PROD1_W'(tv_s1[1]) * PROD1_W'(e1_s1[0]);
	end

	always_ff @(posedge clk) begin
		e1_s3 <= e1_s2;
		e2_s3 <= e2_s2;
		tv_s3 <= tv_s2;
		d_s3  <= d_s2;
		for (int i = 0; i < 3; i++) begin
			p_s3[i] <= CROSS_W'(pp_s2[2 * i]) - CROSS_W'(pp_s2[2 * i + 1]);
			q_s3[i] <= CROSS_W'(qp_s2[2 * i]) - CROSS_W'(qp_s2[2 * i + 1]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dp_s4[i] <= PROD2_W'(e1_s3[i]) * PROD2_W'(p_s3[i]);
			up_s4[i] <= PROD2_W'(tv_s3[i]) * PROD2_W'(p_s3[i]);
			vp_s4[i] <= PROD2_W'(d_s3[i]) * PROD2_W'(q_s3[i]);
			tp_s4[i] <= PROD2_W'(e2_s3[i]) * PROD2_W'(q_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		det_s5 <= SUM_W'(dp_s4[0]) + SUM_W'(dp_s4[1]) + SUM_W'(dp_s4[2]);
		u_s5   <= SUM_W'(up_s4[0]) + SUM_W'(up_s4[1]) + SUM_W'(up_s4[2]);
		v_s5   <= SUM_W'(vp_s4[0]) + SUM_W'(vp_s4[1]) + SUM_W'(vp_s4[2]);
		tn_s5  <= SUM_W'(tp_s4[0]) + SUM_W'(tp_s4[1]) + SUM_W'(tp_s4[2]);
	end

	always_comb begin
		res.valid = valid_s5;
		res.det   = det_s5;
		res.u     = u_s5;
		res.v     = v_s5;
		res.tn    = tn_s5;
	end

endmodule

// ----- rtl/rti_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, lanes sharing one divisor.
module rti_div import rti_pkg::*; #(
	parameter int AW = DIV_W,
	parameter int QB = DIV_STEPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  rti_tag_t                 in_tag,
	input  logic [LANES-1:0][AW-1:0] dividend,
	input  logic [AW-1:0]            divisor,
	output logic                     out_valid,
	output rti_tag_t                 out_tag,
	output logic [LANES-1:0][QB-1:0] quotient
);

	localparam int RW = AW + 1;

	logic                     valid_sk [QB+1];
	rti_tag_t                 tag_sk   [QB+1];
	logic [AW-1:0]            b_sk     [QB+1];
	logic [LANES-1:0][RW-1:0] rem_sk   [QB+1];
	logic [LANES-1:0][QB-1:0] low_sk   [QB+1];
	logic [LANES-1:0][QB-1:0] q_sk     [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QB; k++) begin
				valid_sk[k] <= 1'b0;
			end
		end else begin
			valid_sk[0] <= in_valid;
			for (int k = 0; k < QB; k++) begin
				valid_sk[k + 1] <= valid_sk[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_sk[0] <= in_tag;
		b_sk[0]   <= divisor;
		for (int l = 0; l < LANES; l++) begin
			rem_sk[0][l] <= RW'({dividend[l], {FRAC_W{1'b0}}} >> QB);
			low_sk[0][l] <= {dividend[l][QB-FRAC_W-1:0], {FRAC_W{1'b0}}};
			q_sk[0][l]   <= '0;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [LANES-1:0][RW-1:0] trial;
		logic [LANES-1:0]         ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l] = {rem_sk[k][l][RW-2:0], low_sk[k][l][QB-1]};
				ge[l]    = trial[l] >= {1'b0, b_sk[k]};
			end
		end

		always_ff @(posedge clk) begin
			tag_sk[k + 1] <= tag_sk[k];
			b_sk[k + 1]   <= b_sk[k];
			for (int l = 0; l < LANES; l++) begin
				rem_sk[k + 1][l] <= ge[l] ? trial[l] - {1'b0, b_sk[k]} : trial[l];
				low_sk[k + 1][l] <= {low_sk[k][l][QB-2:0], 1'b0};
				q_sk[k + 1][l]   <= {q_sk[k][l][QB-2:0], ge[l]};
			end
		end
	end

	assign out_valid = valid_sk[QB];
	assign out_tag   = tag_sk[QB];
	assign quotient  = q_sk[QB];

endmodule

// ----- rtl/ray_triangle_intersect.sv -----
// Top level of the pipelined Moller-Trumbore ray-triangle intersector.
// One triangle is taken in every clock cycle and busy is always low. Each
// result appears on the result ports after its start transfer, marked by
// done for one cycle: it passes the edge, cross and dot product stages, a
// hit-test register, a divider that forms one quotient bit per stage for t,
// u and v together, and one output register.
// The ray is set through the write port and must not change while triangles
// are in flight.
module ray_triangle_intersect import rti_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_write,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [COORD_W-1:0]        cfg_data,
	input  logic signed [COORD_W-1:0] vertex0_x,
	input  logic signed [COORD_W-1:0] vertex0_y,
	input  logic signed [COORD_W-1:0] vertex0_z,
	input  logic signed [COORD_W-1:0] vertex1_x,
	input  logic signed [COORD_W-1:0] vertex1_y,
	input  logic signed [COORD_W-1:0] vertex1_z,
	input  logic signed [COORD_W-1:0] vertex2_x,
	input  logic signed [COORD_W-1:0] vertex2_y,
	input  logic signed [COORD_W-1:0] vertex2_z,
	output logic                      done,
	output logic                      hit,
	output logic signed [T_W-1:0]     distance_t,
	output logic [BARY_W-1:0]         bary_u,
	output logic [BARY_W-1:0]         bary_v
);

	localparam int LATENCY = FRONT_STAGES + 1 + (DIV_STEPS + 1) + 1;

	logic signed [COORD_W-1:0] org_q [3];
	logic signed [COORD_W-1:0] dir_q [3];
	logic signed [COORD_W-1:0] vtx [9];
	rti_front_t                front;

	logic                      valid_s6, hit_s6, neg_s6;
	logic [DIV_W-1:0]          det_s6;
	logic [LANES-1:0][DIV_W-1:0] num_s6;
	logic                      sat;
	rti_tag_t                  tag_in, tag_out;
	logic                      div_valid;
	logic [LANES-1:0][DIV_STEPS-1:0] quo;

	logic                      done_q, hit_q;
	logic signed [T_W-1:0]     t_q;
	logic [BARY_W-1:0]         u_q, v_q;

	logic signed [SUM_W:0]     uv_sum;
	logic                      hit_c;
	logic [DIV_W-1:0]          tmag;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= DIR_Z_RESET;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:    org_q[0] <= cfg_data;
				REG_ORIGIN_Y:    org_q[1] <= cfg_data;
				REG_ORIGIN_Z:    org_q[2] <= cfg_data;
				REG_DIRECTION_X: dir_q[0] <= cfg_data;
				REG_DIRECTION_Y: dir_q[1] <= cfg_data;
				REG_DIRECTION_Z: dir_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign vtx[0] = vertex0_x;
	assign vtx[1] = vertex0_y;
	assign vtx[2] = vertex0_z;
	assign vtx[3] = vertex1_x;
	assign vtx[4] = vertex1_y;
	assign vtx[5] = vertex1_z;
	assign vtx[6] = vertex2_x;
	assign vtx[7] = vertex2_y;
	assign vtx[8] = vertex2_z;

	rti_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(start && !busy),
		.org(org_q),
		.dir(dir_q),
		.vtx(vtx),
		.res(front)
	);

	always_comb begin
		uv_sum = (SUM_W + 1)'(front.u) + (SUM_W + 1)'(front.v);
		hit_c  = (front.det != '0) && !front.u[SUM_W-1] && (front.u <= front.det)
			&& !front.v[SUM_W-1] && (uv_sum <= (SUM_W + 1)'(front.det));
		tmag   = front.tn[SUM_W-1] ? DIV_W'(-front.tn) : DIV_W'(front.tn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= front.valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_s6    <= hit_c;
		neg_s6    <= front.tn[SUM_W-1];
		det_s6    <= DIV_W'(front.det);
		num_s6[0] <= tmag;
		num_s6[1] <= DIV_W'(front.u);
		num_s6[2] <= DIV_W'(front.v);
	end

	assign sat = {{(DIV_STEPS - FRAC_W){1'b0}}, num_s6[0]}
		>= {det_s6, {(DIV_STEPS - FRAC_W){1'b0}}};

	always_comb begin
		tag_in.hit = hit_s6;
		tag_in.neg = neg_s6;
		tag_in.sat = sat;
	end

	rti_div #(
		.AW(DIV_W),
		.QB(DIV_STEPS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(valid_s6),
		.in_tag(tag_in),
		.dividend(num_s6),
		.divisor(det_s6),
		.out_valid(div_valid),
		.out_tag(tag_out),
		.quotient(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= tag_out.hit;
		if (!tag_out.hit) begin
			t_q <= '0;
			u_q <= '0;
			v_q <= '0;
		end else begin
			if (tag_out.sat) begin
				t_q <= tag_out.neg ? {1'b1, {(T_W - 1){1'b0}}} : {1'b0, {(T_W - 1){1'b1}}};
			end else begin
				t_q <= tag_out.neg ? -T_W'(quo[0]) : T_W'(quo[0]);
			end
			u_q <= quo[1][BARY_W-1:0];
			v_q <= quo[2][BARY_W-1:0];
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign distance_t = t_q;
	assign bary_u     = u_q;
	assign bary_v     = v_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("Result strobe without a start transfer at the pipeline depth.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (distance_t == '0 && bary_u == '0 && bary_v == '0))
		else $error("Miss result carries nonzero fields.");

	a_bary_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> ({1'b0, bary_u} + {1'b0, bary_v} <= 18'h10000))
		else $error("Barycentric coordinates of a hit sum above one.");

endmodule

// ----- test/tb_ray_triangle_intersect.sv -----
// Self-checking testbench for ray_triangle_intersect with directed and random triangles.
module tb_ray_triangle_intersect import rti_pkg::*; ();

	localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int PIPE_CYCLES = 45;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 184;
	localparam int DIR_ROWS = 10;

	typedef struct packed {
		logic             hit;
		logic [T_W-1:0]   t;
		logic [BARY_W-1:0] u;
		logic [BARY_W-1:0] v;
	} isect_t;

	localparam isect_t MISS = '{hit: 1'b0, t: '0, u: '0, v: '0};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic busy_s;
	logic cfg_write;
	logic [IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic signed [COORD_W-1:0] vtx [9];
	logic done;
	logic hit;
	logic signed [T_W-1:0] distance_t;
	logic [BARY_W-1:0] bary_u;
	logic [BARY_W-1:0] bary_v;

	logic signed [COORD_W-1:0] ray [6];
	isect_t pending_hits [$];
	int fails = 0;
	int cycles = 0;

	logic [COORD_W-1:0] dir_vtx [DIR_ROWS][9] = '{
		'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000},
		'{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0100,
			16'h0100, 16'h0000, 16'h0100},
		'{16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 16'h0100,
			16'h0000, 16'h0100, 16'h0100},
		'{16'h0000, 16'h0000, 16'hFF00, 16'h0000, 16'h0100, 16'hFF00,
			16'h0100, 16'h0000, 16'hFF00},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'h7FFF, 16'h7FFF},
		'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
			16'h8000, 16'h8000, 16'h8000},
		'{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			16'h8000, 16'h7FFF, 16'h7FFF},
		'{16'hC000, 16'hC000, 16'h0100, 16'hC000, 16'h3FFF, 16'h0100,
			16'h3FFF, 16'hC000, 16'h0100},
		'{16'hFF00, 16'h0000, 16'h0100, 16'hFF00, 16'h0100, 16'h0100,
			16'h0000, 16'h0000, 16'h0100},
		'{16'h0000, 16'hFF00, 16'h7FFF, 16'h0000, 16'h0100, 16'h7FFF,
			16'h0100, 16'h0000, 16'h7FFF}
	};
	// Rows with typed=0 are checked against the predictor instead.
	bit dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 0, 0, 0, 0};
	isect_t dir_want [DIR_ROWS] = '{
		MISS,
		'{hit: 1'b1, t: 32'h0001_0000, u: '0, v: '0},
		MISS,
		'{hit: 1'b1, t: 32'hFFFF_0000, u: '0, v: '0},
		MISS, MISS, MISS, MISS, MISS, MISS
	};

	ray_triangle_intersect u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.vertex0_x(vtx[0]), .vertex0_y(vtx[1]), .vertex0_z(vtx[2]),
		.vertex1_x(vtx[3]), .vertex1_y(vtx[4]), .vertex1_z(vtx[5]),
		.vertex2_x(vtx[6]), .vertex2_y(vtx[7]), .vertex2_z(vtx[8]),
		.done(done), .hit(hit), .distance_t(distance_t),
		.bary_u(bary_u), .bary_v(bary_v)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned ratio_q16(longint unsigned num, longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		longint unsigned f;
		q = num / den;
		r = num % den;
		f = 0;
		if (q >= 64'h8000)
			return 64'h8000_0000;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			f = f << 1;
			if (r >= den) begin
				r = r - den;
				f = f | 1;
			end
		end
		return (q << 16) | f;
	endfunction

	function automatic isect_t predict_hit(logic signed [COORD_W-1:0] tri_v [9]);
		longint o [3], d [3], e1 [3], e2 [3], pv [3], tv [3], qv [3];
		longint det, uu, vv, tn;
		longint unsigned tm;
		isect_t res;
		for (int i = 0; i < 3; i++) begin
			o[i] = ray[i];
			d[i] = ray[3+i];
			e1[i] = longint'(tri_v[3+i]) - longint'(tri_v[i]);
			e2[i] = longint'(tri_v[6+i]) - longint'(tri_v[i]);
			tv[i] = o[i] - longint'(tri_v[i]);
		end
		pv[0] = d[1] * e2[2] - d[2] * e2[1];
		pv[1] = d[2] * e2[0] - d[0] * e2[2];
		pv[2] = d[0] * e2[1] - d[1] * e2[0];
		det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
		res = MISS;
		if (det == 0)
			return res;
		uu = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
		if (uu < 0 || uu > det)
			return res;
		qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
		qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
		qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
		vv = d[0] * qv[0] + d[1] * qv[1] + d[2] * qv[2];
		if (vv < 0 || uu + vv > det)
			return res;
		tn = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
		tm = ratio_q16(tn < 0 ? -tn : tn, det);
		if (tn < 0)
			res.t = (tm >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-tm);
		else
			res.t = (tm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(tm);
		res.hit = 1'b1;
		res.u = BARY_W'(ratio_q16(uu, det));
		res.v = BARY_W'(ratio_q16(vv, det));
		return res;
	endfunction

	always @(negedge clk) begin
		busy_s <= busy;
	end

	always @(negedge clk) begin
		isect_t got;
		isect_t want;
		if (arst_n && done) begin
			got = '{hit: hit, t: distance_t, u: bary_u, v: bary_v};
			if (pending_hits.size() == 0) begin
				$display("%0t: result transfer with nothing expected: %p", $time, got);
				fails++;
			end else begin
				want = pending_hits.pop_front();
				if (got.hit !== want.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
					fails++;
				end
				if (got.t !== want.t) begin
					$display("%0t: distance_t expected %h actual %h", $time, want.t, got.t);
					fails++;
				end
				if (got.u !== want.u) begin
					$display("%0t: bary_u expected %h actual %h", $time, want.u, got.u);
					fails++;
				end
				if (got.v !== want.v) begin
					$display("%0t: bary_v expected %h actual %h", $time, want.v, got.v);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[ray_triangle_intersect] ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx < 6)
			ray[idx] = data;
	endtask

	task automatic drain;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic send_triangle(logic signed [COORD_W-1:0] tri_v [9], int gap,
			bit typed, isect_t want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		for (int i = 0; i < 9; i++)
			vtx[i] <= tri_v[i];
		@(posedge clk);
		while (busy_s)
			@(posedge clk);
		pending_hits.push_back(typed ? want : predict_hit(tri_v));
	endtask

	task automatic random_triangle(output logic signed [COORD_W-1:0] tri_v [9]);
		int sel;
		int dmax;
		int kmax;
		int k;
		int spread;
		longint c [3];
		sel = $urandom_range(0, 99);
		if (sel < 20) begin
			for (int i = 0; i < 9; i++)
				tri_v[i] = COORD_W'($urandom);
			return;
		end
		dmax = 1;
		for (int i = 3; i < 6; i++)
			if ((ray[i] < 0 ? -int'(ray[i]) : int'(ray[i])) > dmax)
				dmax = ray[i] < 0 ? -int'(ray[i]) : int'(ray[i]);
		kmax = 65535 / dmax;
		k = $urandom_range(0, 2 * kmax) - kmax;
		case ($urandom_range(0, 3))
			0: spread = 4;
			1: spread = 64;
			2: spread = 1024;
			default: spread = 16384;
		endcase
		for (int i = 0; i < 3; i++)
			c[i] = longint'(ray[i]) + longint'(k) * longint'(ray[3+i]);
		for (int i = 0; i < 9; i++)
			tri_v[i] = COORD_W'(c[i % 3] + $urandom_range(0, 2 * spread) - spread);
		if (sel >= 90)
			tri_v[$urandom_range(0, 8)] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
	endtask

	initial begin
		logic signed [COORD_W-1:0] tri_v [9];
		logic [COORD_W-1:0] ray_set [6];
		int gap;
		arst_n = 1'b0;
		start = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		for (int i = 0; i < 9; i++)
			vtx[i] = '0;
		for (int i = 0; i < 6; i++)
			ray[i] = '0;
		ray[REG_DIRECTION_Z] = DIR_Z_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++) begin
			for (int i = 0; i < 9; i++)
				tri_v[i] = dir_vtx[r][i];
			send_triangle(tri_v, $urandom_range(0, 1), dir_typed[r], dir_want[r]);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				start <= 1'b0;
				drain();
				case (ph)
					1: ray_set = '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0001};
					2: ray_set = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF};
					3: ray_set = '{16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF};
					default: begin
						for (int i = 0; i < 3; i++)
							ray_set[i] = COORD_W'($urandom_range(0, 4000) - 2000);
						for (int i = 3; i < 6; i++)
							ray_set[i] = COORD_W'($urandom_range(0, 1024) - 512);
					end
				endcase
				write_reg(REG_ORIGIN_X, ray_set[0]);
				write_reg(REG_ORIGIN_Y, ray_set[1]);
				write_reg(REG_ORIGIN_Z, ray_set[2]);
				write_reg(REG_DIRECTION_X, ray_set[3]);
				write_reg(REG_DIRECTION_Y, ray_set[4]);
				write_reg(REG_DIRECTION_Z, ray_set[5]);
				write_reg(REG_SPARE_6, COORD_W'($urandom));
				write_reg(REG_SPARE_7, COORD_W'($urandom));
				cfg_write <= 1'b0;
				@(posedge clk);
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_triangle(tri_v);
				gap = (ph == 1) ? 0 : $urandom_range(0, 3);
				if (ph == 4 && n == PHASE_ITEMS / 2) begin
					start <= 1'b0;
					while (pending_hits.size() != 0)
						@(posedge clk);
					gap = 0;
				end
				send_triangle(tri_v, gap, 1'b0, MISS);
			end
		end

		start <= 1'b0;
		drain();
		if (fails == 0)
			$display("[ray_triangle_intersect] OK");
		else
			$display("[ray_triangle_intersect] ERROR");
		$finish;
	end

endmodule
